/* rtl/akdd_pkg.sv */
// Shared types, constants and the level decode for the analog keypad debounce block.
// No dependencies; every other file in rtl/ refers to this package by scoped names.
package akdd_pkg;

  localparam int NOW_W       = 32;
  localparam int INTERVAL_W  = 16;
  localparam int TOL_W       = 10;
  localparam int LEVEL_W     = 12;
  localparam int KEY_W       = 3;
  localparam int OUT_TDATA_W = 8;
  localparam int CFG_IDX_W   = 8;
  localparam int CFG_DATA_W  = 16;

  localparam int ADC_BITS_DEF       = 10;
  localparam int WINDOW_SAMPLES_DEF = 5;
  localparam int MIN_MATCHES        = 2;

  localparam logic [INTERVAL_W-1:0] INTERVAL_RST = 16'd10;
  localparam logic [TOL_W-1:0]      TOL_RST      = 10'd20;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SAMPLE_INTERVAL = 8'd0,
    REG_MATCH_TOLERANCE = 8'd1
  } cfg_reg_t;

  typedef enum logic [KEY_W-1:0] {
    KEY_NONE  = 3'd0,
    KEY_ONE   = 3'd1,
    KEY_TWO   = 3'd2,
    KEY_THREE = 3'd3,
    KEY_FOUR  = 3'd4
  } key_code_t;

  typedef struct packed {
    logic [INTERVAL_W-1:0] sample_interval_ms;
    logic [TOL_W-1:0]      match_tolerance;
  } cfg_t;

  // The ladder bands are hundreds of counts wide, so the quotient by 100 is
  // a set of range checks.
  function automatic key_code_t decode_level(input logic [LEVEL_W-1:0] level);
    key_code_t code;
    if (level inside {[12'd300:12'd399]}) begin
      code = KEY_ONE;
    end else if (level inside {[12'd500:12'd599]}) begin
      code = KEY_TWO;
    end else if (level inside {[12'd600:12'd699]}) begin
      code = KEY_THREE;
    end else if (level inside {[12'd700:12'd799]}) begin
      code = KEY_FOUR;
    end else begin
      code = KEY_NONE;
    end
    return code;
  endfunction

endpackage

/* rtl/analog_keypad_debounce_decode.sv */
// Top level of the analog keypad debounce and decode block.
// Depends on akdd_pkg, akdd_cfg_regs and akdd_debounce.

// One poll (timestamp plus converter sample) is taken per clock cycle, as
// long as the output is not stalled, and yields exactly one key-code beat.
// A poll is held in the input register, where the debounce state is updated
// and the key code decoded in a single pass, and the code is then registered
// into the output register and offered from there. The input side keeps
// accepting while a result waits, as long as the output register is free or
// being drained in that cycle. Configuration writes are always taken and
// must be made while no poll is in flight.
module analog_keypad_debounce_decode #(
  parameter int ADC_BITS       = akdd_pkg::ADC_BITS_DEF,
  parameter int WINDOW_SAMPLES = akdd_pkg::WINDOW_SAMPLES_DEF
) (
  input  logic                                              clk,
  input  logic                                              rst,
  input  logic                                              s_tvalid,
  output logic                                              s_tready,
  // [31:0] now_ms, [32+ADC_BITS-1:32] adc_sample, rest zero padding
  input  logic [((akdd_pkg::NOW_W+ADC_BITS+7)/8)*8-1:0]     s_tdata,
  output logic                                              m_tvalid,
  input  logic                                              m_tready,
  // [2:0] key_code, rest zero
  output logic [akdd_pkg::OUT_TDATA_W-1:0]                  m_tdata,
  input  logic                                              cfg_valid,
  output logic                                              cfg_ready,
  input  logic [akdd_pkg::CFG_IDX_W-1:0]                    cfg_index,
  input  logic [akdd_pkg::CFG_DATA_W-1:0]                   cfg_data
);

  akdd_pkg::cfg_t cfg;

  logic                       stage_valid;
  logic [akdd_pkg::NOW_W-1:0] stage_now;
  logic [ADC_BITS-1:0]        stage_sample;
  logic                       advance;
  logic [ADC_BITS-1:0]        held_level_next;
  akdd_pkg::key_code_t        key_code;

  akdd_cfg_regs u_cfg_regs (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  akdd_debounce #(
    .ADC_BITS       (ADC_BITS),
    .WINDOW_SAMPLES (WINDOW_SAMPLES)
  ) u_debounce (
    .clk             (clk),
    .rst             (rst),
    .step            (advance),
    .now_ms          (stage_now),
    .adc_sample      (stage_sample),
    .cfg             (cfg),
    .held_level_next (held_level_next)
  );

  assign advance  = stage_valid && (!m_tvalid || m_tready);
  assign s_tready = !stage_valid || advance;
  assign key_code = akdd_pkg::decode_level(akdd_pkg::LEVEL_W'(held_level_next));

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      stage_valid <= 1'b1;
    end else if (advance) begin
      stage_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      stage_now    <= s_tdata[akdd_pkg::NOW_W-1:0];
      stage_sample <= s_tdata[akdd_pkg::NOW_W +: ADC_BITS];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      m_tdata <= akdd_pkg::OUT_TDATA_W'(key_code);
    end
  end

`ifndef SYNTHESIS
  a_stage_held_on_stall: assert property (@(posedge clk) disable iff (rst)
    (stage_valid && m_tvalid && !m_tready) |=> stage_valid && $stable(stage_now))
    else $error("polled item lost while the output stalled");

  a_advance_gives_beat: assert property (@(posedge clk) disable iff (rst)
    advance |=> m_tvalid)
    else $error("processed poll produced no result beat");

  a_key_code_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata <= akdd_pkg::OUT_TDATA_W'(akdd_pkg::KEY_FOUR))
    else $error("key code out of range");
`endif

endmodule

/* rtl/akdd_cfg_regs.sv */
// Configuration registers: sample interval and match tolerance.
// Depends on akdd_pkg for register indexes, widths and reset values.
module akdd_cfg_regs (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [akdd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [akdd_pkg::CFG_DATA_W-1:0] cfg_data,
  output akdd_pkg::cfg_t                 cfg
);

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.sample_interval_ms <= akdd_pkg::INTERVAL_RST;
      cfg.match_tolerance    <= akdd_pkg::TOL_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        akdd_pkg::REG_SAMPLE_INTERVAL: begin
          cfg.sample_interval_ms <= cfg_data[akdd_pkg::INTERVAL_W-1:0];
        end
        akdd_pkg::REG_MATCH_TOLERANCE: begin
          cfg.match_tolerance <= cfg_data[akdd_pkg::TOL_W-1:0];
        end
        default: begin
          // Writes to unknown indexes are dropped.
        end
      endcase
    end
  end

endmodule

/* rtl/akdd_debounce.sv */
// Debounce state: sample pacing, window reference, match counting and held level.
// Depends on akdd_pkg for the configuration struct and widths.
module akdd_debounce #(
  parameter int ADC_BITS       = akdd_pkg::ADC_BITS_DEF,
  parameter int WINDOW_SAMPLES = akdd_pkg::WINDOW_SAMPLES_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        step,
  input  logic [akdd_pkg::NOW_W-1:0]  now_ms,
  input  logic [ADC_BITS-1:0]         adc_sample,
  input  akdd_pkg::cfg_t              cfg,
  output logic [ADC_BITS-1:0]         held_level_next
);

  localparam int CNT_W = $clog2(WINDOW_SAMPLES + 1);
  localparam int CMP_W = (ADC_BITS > akdd_pkg::TOL_W) ? ADC_BITS : akdd_pkg::TOL_W;

  logic [akdd_pkg::NOW_W-1:0] last_sample_time;
  logic [CNT_W-1:0]           window_count;
  logic [CNT_W-1:0]           match_count;
  logic [ADC_BITS-1:0]        window_reference;
  logic [ADC_BITS-1:0]        held_level;

  logic [akdd_pkg::NOW_W-1:0] elapsed;
  logic                       take;
  logic [ADC_BITS-1:0]        reference_next;
  logic [ADC_BITS-1:0]        diff;
  logic                       match;
  logic [CNT_W-1:0]           window_count_next;
  logic [CNT_W-1:0]           match_count_next;
  logic                       window_full;

  always_comb begin
    elapsed = now_ms - last_sample_time;
    take    = step && (elapsed > akdd_pkg::NOW_W'(cfg.sample_interval_ms));

    reference_next = (take && window_count == '0) ? adc_sample : window_reference;
    diff  = (adc_sample >= reference_next) ? adc_sample - reference_next
                                           : reference_next - adc_sample;
    match = CMP_W'(diff) < CMP_W'(cfg.match_tolerance);

    window_count_next = take ? window_count + CNT_W'(1) : window_count;
    match_count_next  = (take && match) ? match_count + CNT_W'(1) : match_count;
    window_full       = window_count_next == CNT_W'(WINDOW_SAMPLES);

    // A closed window with enough matches promotes its reference.
    if (window_full && match_count_next > CNT_W'(akdd_pkg::MIN_MATCHES)) begin
      held_level_next = reference_next;
    end else begin
      held_level_next = held_level;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_sample_time <= '0;
      window_count     <= '0;
      match_count      <= '0;
      window_reference <= '0;
      held_level       <= '0;
    end else if (step) begin
      if (take) begin
        last_sample_time <= now_ms;
      end
      window_count     <= window_full ? '0 : window_count_next;
      match_count      <= window_full ? '0 : match_count_next;
      window_reference <= reference_next;
      held_level       <= held_level_next;
    end
  end

`ifndef SYNTHESIS
  a_window_in_range: assert property (@(posedge clk) disable iff (rst)
    window_count < CNT_W'(WINDOW_SAMPLES))
    else $error("window count reached the window length");

  a_matches_bounded: assert property (@(posedge clk) disable iff (rst)
    match_count <= window_count)
    else $error("more matches than samples in the window");

  a_held_only_on_step: assert property (@(posedge clk) disable iff (rst)
    !step |=> $stable(held_level) && $stable(window_count))
    else $error("debounce state moved without a poll");

  a_no_sample_no_time: assert property (@(posedge clk) disable iff (rst)
    (step && !take) |=> $stable(last_sample_time) && $stable(window_count))
    else $error("rejected sample changed the window");
`endif

endmodule

/* dv/tb_top.sv */
// Self-checking bench for analog_keypad_debounce_decode: timed polls with a
// bit-accurate debounce predictor and checking of every key-code beat.
// Depends on rtl/akdd_pkg.sv and rtl/analog_keypad_debounce_decode.sv.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import akdd_pkg::*;

  localparam int SAMPLE_W = ADC_BITS_DEF;
  localparam int IN_W     = ((NOW_W + SAMPLE_W + 7) / 8) * 8;

  // Indexes outside the register map; writes to them must change nothing.
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_LOW = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_TOP = 8'hFF;

  logic clk = 1'b0;
  logic rst;
  logic s_tvalid;
  logic s_tready;
  // [31:0] now_ms, [41:32] adc_sample, [47:42] zero padding
  logic [IN_W-1:0] s_tdata;
  logic m_tvalid;
  logic m_tready;
  // [2:0] key_code, [7:3] zero padding
  logic [OUT_TDATA_W-1:0] m_tdata;
  logic cfg_valid;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  // Predictor copy of the registers and debounce state.
  logic [INTERVAL_W-1:0] cur_interval;
  logic [TOL_W-1:0]      cur_tol;
  logic [NOW_W-1:0]      last_accept_ms;
  logic [2:0]            win_cnt;
  logic [2:0]            hit_cnt;
  logic [SAMPLE_W-1:0]   win_ref;
  logic [SAMPLE_W-1:0]   held_lvl;

  key_code_t pending_keys[$];
  key_code_t want_key;
  logic [NOW_W-1:0] ms_clock;
  int src_idle_pct;
  int sink_stall_pct;
  int err_count;
  int polls_sent;
  int keys_checked;
  int reg_writes;

  analog_keypad_debounce_decode u_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic key_code_t level_to_key(input logic [SAMPLE_W-1:0] lvl);
    key_code_t code;
    case (lvl / 100)
      3: code = KEY_ONE;
      5: code = KEY_TWO;
      6: code = KEY_THREE;
      7: code = KEY_FOUR;
      default: code = KEY_NONE;
    endcase
    return code;
  endfunction

  function automatic void reset_debounce();
    cur_interval   = INTERVAL_RST;
    cur_tol        = TOL_RST;
    last_accept_ms = '0;
    win_cnt        = '0;
    hit_cnt        = '0;
    win_ref        = '0;
    held_lvl       = '0;
  endfunction

  // Advances the debounce state by one poll and returns the key it shows.
  function automatic key_code_t debounce_poll(input logic [NOW_W-1:0] now,
                                              input logic [SAMPLE_W-1:0] sample);
    logic [NOW_W-1:0]    elapsed;
    logic [SAMPLE_W-1:0] delta;
    elapsed = now - last_accept_ms;
    if (elapsed > NOW_W'(cur_interval)) begin
      last_accept_ms = now;
      if (win_cnt == 3'd0) begin
        win_ref = sample;
      end
      delta = (sample >= win_ref) ? sample - win_ref : win_ref - sample;
      if (delta < cur_tol) begin
        hit_cnt = hit_cnt + 3'd1;
      end
      win_cnt = win_cnt + 3'd1;
    end
    if (win_cnt == 3'(WINDOW_SAMPLES_DEF)) begin
      win_cnt = '0;
      if (hit_cnt > 3'(MIN_MATCHES)) begin
        held_lvl = win_ref;
      end
      hit_cnt = '0;
    end
    return level_to_key(held_lvl);
  endfunction

  task automatic report_mismatch(input string msg);
    if (err_count < 40) begin
      $display("[%0t] MISMATCH: %s", $realtime, msg);
    end
    err_count++;
  endtask

  task automatic send_poll(input logic [NOW_W-1:0] now, input logic [SAMPLE_W-1:0] sample);
    int gap;
    logic [IN_W-1:0] beat;
    beat = '0;
    beat[NOW_W-1:0] = now;
    beat[NOW_W +: SAMPLE_W] = sample;
    if (src_idle_pct != 0 && $urandom_range(99) < src_idle_pct) begin
      gap = $urandom_range(1, 3);
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= beat;
    do @(posedge clk); while (!s_tready);
    pending_keys.push_back(debounce_poll(now, sample));
    polls_sent++;
  endtask

  task automatic poll_after(input logic [NOW_W-1:0] step, input int sample);
    ms_clock = ms_clock + step;
    send_poll(ms_clock, SAMPLE_W'(sample));
  endtask

  task automatic wait_idle();
    s_tvalid <= 1'b0;
    while (pending_keys.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      REG_SAMPLE_INTERVAL: cur_interval = val[INTERVAL_W-1:0];
      REG_MATCH_TOLERANCE: cur_tol = val[TOL_W-1:0];
      default: ;
    endcase
    reg_writes++;
    @(posedge clk);
  endtask

  // Key code checker and receiver-side stalls.
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (pending_keys.size() == 0) begin
        report_mismatch($sformatf("key beat 0x%02h with no poll pending", m_tdata));
      end else begin
        want_key = pending_keys.pop_front();
        if (m_tdata[KEY_W-1:0] != want_key) begin
          report_mismatch($sformatf("key_code got %0d want %0d", m_tdata[KEY_W-1:0],
                                    want_key));
        end
        if (m_tdata[OUT_TDATA_W-1:KEY_W] != '0) begin
          report_mismatch($sformatf("key beat padding 0x%02h not zero", m_tdata));
        end
        keys_checked++;
      end
    end
    m_tready <= ($urandom_range(99) >= sink_stall_pct);
  end

  // Reset values, an ignored first poll, an interval boundary, keys one, two
  // and four and converter extremes mixed into a window that still debounces.
  task automatic test_reset_and_keys();
    ms_clock = '0;
    poll_after(0, 500);
    poll_after(10, 500);
    poll_after(11, 350);
    poll_after(11, 360);
    poll_after(11, 0);
    poll_after(11, 345);
    poll_after(11, 1023);
    poll_after(11, 550);
    poll_after(12, 569);
    poll_after(13, 540);
    poll_after(11, 700);
    poll_after(11, 531);
    poll_after(11, 750);
    poll_after(11, 750);
    poll_after(11, 731);
    poll_after(11, 769);
    poll_after(11, 749);
  endtask

  // A window whose timestamps run across the 32-bit wrap.
  task automatic test_timestamp_wrap();
    ms_clock = 32'hFFFF_FFE0;
    poll_after(11, 650);
    poll_after(11, 640);
    poll_after(11, 660);
    poll_after(11, 655);
    poll_after(11, 651);
  endtask

  // Writes to unmapped indexes, bits above the register width, interval
  // zero, the widest interval and zero tolerance.
  task automatic test_register_bounds();
    wait_idle();
    write_reg(REG_SAMPLE_INTERVAL, 16'd0);
    write_reg(REG_MATCH_TOLERANCE, 16'hFFFF);
    write_reg(REG_UNUSED_LOW, 16'd0);
    write_reg(REG_UNUSED_TOP, 16'hFFFF);
    poll_after(0, 300);
    poll_after(1, 1023);
    poll_after(1, 0);
    poll_after(1, 500);
    poll_after(1, 1);
    poll_after(1, 1022);
    wait_idle();
    write_reg(REG_SAMPLE_INTERVAL, 16'hFFFF);
    write_reg(REG_MATCH_TOLERANCE, 16'd0);
    // With zero tolerance nothing matches, so the held level must stay.
    poll_after(32'h0001_0000, 650);
    poll_after(32'h0001_0000, 650);
    poll_after(32'h0001_0000, 650);
    poll_after(32'h0001_0000, 650);
    poll_after(32'h0001_0000, 650);
  endtask

  // Mostly settled key presses with noise inside the tolerance, plus polls
  // that come too early, stray readings and jumps of the millisecond clock.
  task automatic run_random_phase(input int n_polls, input logic [INTERVAL_W-1:0] interval,
                                  input logic [TOL_W-1:0] tol, input int idle_pct,
                                  input int stall_pct);
    int target;
    int left_on_level;
    int pick;
    int spread;
    int sample;
    int roll;
    logic [NOW_W-1:0] step;
    wait_idle();
    src_idle_pct   = idle_pct;
    sink_stall_pct = stall_pct;
    write_reg(REG_SAMPLE_INTERVAL, CFG_DATA_W'(interval));
    write_reg(REG_MATCH_TOLERANCE, CFG_DATA_W'(tol));
    left_on_level = 0;
    target = 0;
    for (int i = 0; i < n_polls; i++) begin
      if (left_on_level == 0) begin
        pick = $urandom_range(6);
        case (pick)
          0: target = 350;
          1: target = 550;
          2: target = 650;
          3: target = 750;
          4: target = 450;
          5: target = 90;
          default: target = $urandom_range(1023);
        endcase
        left_on_level = $urandom_range(5, 15);
      end
      left_on_level--;
      spread = (cur_tol == 0) ? 0 : int'(cur_tol) - 1;
      sample = target + int'($urandom_range(0, 2 * spread)) - spread;
      if (sample < 0) sample = 0;
      if (sample > 1023) sample = 1023;
      roll = $urandom_range(99);
      if (roll < 8) begin
        ms_clock = $urandom;
        send_poll(ms_clock, SAMPLE_W'($urandom_range(1023)));
      end else begin
        if (roll < 20) begin
          step = $urandom_range(0, cur_interval);
        end else if (roll < 30) begin
          step = NOW_W'(cur_interval) + 1 + $urandom_range(0, 32'h00FF_FFFF);
        end else begin
          step = NOW_W'(cur_interval) + 1 + $urandom_range(0, 5);
        end
        if ($urandom_range(99) < 12) begin
          sample = $urandom_range(1023);
        end
        poll_after(step, sample);
      end
    end
  endtask

  task automatic test_random_traffic();
    run_random_phase(140, 16'd10, 10'd20, 0, 0);
    run_random_phase(140, 16'd0, 10'd1, 63, 0);
    run_random_phase(140, 16'hFFFF, 10'd1023, 0, 63);
    run_random_phase(140, INTERVAL_W'($urandom_range(65535)), TOL_W'($urandom_range(1, 1023)),
                     35, 35);
    run_random_phase(140, 16'd3, 10'd40, 0, 0);
    run_random_phase(140, INTERVAL_W'($urandom_range(100)), TOL_W'($urandom_range(1, 200)),
                     63, 0);
    run_random_phase(140, 16'hFFFF, 10'd1, 0, 63);
    run_random_phase(140, 16'd0, 10'd1023, 35, 35);
  endtask

  initial begin
    rst            = 1'b1;
    s_tvalid       = 1'b0;
    s_tdata        = '0;
    m_tready       = 1'b0;
    cfg_valid      = 1'b0;
    cfg_index      = '0;
    cfg_data       = '0;
    src_idle_pct   = 0;
    sink_stall_pct = 0;
    err_count      = 0;
    polls_sent     = 0;
    keys_checked   = 0;
    reg_writes     = 0;
    ms_clock       = '0;
    reset_debounce();
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    test_reset_and_keys();
    test_timestamp_wrap();
    test_register_bounds();
    test_random_traffic();
    wait_idle();
    repeat (10) @(posedge clk);
    if (pending_keys.size() != 0) begin
      report_mismatch($sformatf("%0d key beats never arrived", pending_keys.size()));
    end
    $display("Sent %0d polls, checked %0d key beats, made %0d register writes.",
             polls_sent, keys_checked, reg_writes);
    $display("Covered timestamp wrap, interval 0 to 65535, tolerance 0 to 1023, %s",
             "four stall mixes.");
    if (err_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Timed out with %0d key beats pending.", pending_keys.size());
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

/* sim.f */
rtl/akdd_pkg.sv
rtl/akdd_cfg_regs.sv
rtl/akdd_debounce.sv
rtl/analog_keypad_debounce_decode.sv
dv/tb_top.sv
